FILE: src/ssm_pkg.sv
package ssm_pkg;

  localparam int DATA_W = 16;
  localparam int CH_W   = 3;
  localparam int NUM_W  = 32;
  localparam int DEN_W  = 17;

  typedef struct packed {
    logic cap;
    logic mul;
    logic start;
  } ssm_ctrl_t;

  typedef struct packed {
    logic [DATA_W-1:0] y_min;
    logic [DATA_W-1:0] y_max;
    logic [DEN_W-1:0]  dmag;
    logic              dneg;
    logic [DATA_W-1:0] off;
  } ssm_lane_cfg_t;

endpackage

FILE: src/ssm_div.sv
module ssm_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 17,
  parameter int Q_W   = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic             neg_i,
  output logic             busy_o,
  output logic [Q_W-1:0]   quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] acc_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic             neg_q, zero_q;
  logic [DEN_W:0]   trial, diff;
  logic             fits;
  logic [Q_W-1:0]   qraw;

  assign trial = {rem_q, acc_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = CNT_W'(NUM_W);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q  <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
      neg_q  <= neg_i;
      zero_q <= (den_i == '0);
    end else if (cnt_q != '0) begin
      rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      acc_q <= {acc_q[NUM_W-2:0], fits};
    end
  end

  assign qraw   = acc_q[Q_W-1:0];
  assign busy_o = (cnt_q != '0);
  assign quot_o = zero_q ? '0 : (neg_q ? Q_W'(~qraw + Q_W'(1)) : qraw);

endmodule

FILE: src/ssm_lane.sv
module ssm_lane import ssm_pkg::*; #(
  parameter int H_VAL = 220
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssm_ctrl_t         ctrl_i,
  input  ssm_lane_cfg_t     cfg_i,
  input  logic [DATA_W-1:0] value_i,
  output logic              busy_o,
  output logic [DATA_W-1:0] row_o
);

  logic signed [DATA_W-1:0] vin, ymin, ymax, vc_q;
  logic signed [NUM_W-1:0]  prod;
  logic [NUM_W-1:0]         mag_q;
  logic                     nneg_q;
  logic [DATA_W-1:0]        quot;

  assign vin  = $signed(value_i);
  assign ymin = $signed(cfg_i.y_min);
  assign ymax = $signed(cfg_i.y_max);
  assign prod = NUM_W'(vc_q) * NUM_W'(H_VAL);

  // clamp, then scale by the plot height
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap) begin
      if (vin > ymax) begin
        vc_q <= ymax;
      end else if (vin < ymin) begin
        vc_q <= ymin;
      end else begin
        vc_q <= vin;
      end
    end
    if (ctrl_i.mul) begin
      nneg_q <= prod[NUM_W-1];
      mag_q  <= prod[NUM_W-1] ? NUM_W'(-prod) : NUM_W'(prod);
    end
  end

  ssm_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(DATA_W)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(ctrl_i.start),
    .num_i  (mag_q),
    .den_i  (cfg_i.dmag),
    .neg_i  (nneg_q ^ cfg_i.dneg),
    .busy_o (busy_o),
    .quot_o (quot)
  );

  assign row_o = DATA_W'(H_VAL) - quot + cfg_i.off;

endmodule

FILE: src/ssm_col.sv
module ssm_col import ssm_pkg::*; #(
  parameter int PLOT_WIDTH  = 320,
  parameter int LEFT_MARGIN = 30
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssm_ctrl_t         ctrl_i,
  input  logic [DATA_W-1:0] time_i,
  input  logic [DATA_W-1:0] wrap_cnt_i,
  input  logic [DATA_W-1:0] trange_i,
  output logic              busy_o,
  output logic [DATA_W-1:0] col_o
);

  localparam int SPAN = PLOT_WIDTH - LEFT_MARGIN;

  logic [DATA_W-1:0] base, rel_q, quot;
  logic [NUM_W-1:0]  prod_q;

  assign base = DATA_W'(wrap_cnt_i * trange_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap) begin
      rel_q <= time_i - base;
    end
    if (ctrl_i.mul) begin
      prod_q <= NUM_W'(NUM_W'(rel_q) * NUM_W'(SPAN));
    end
  end

  ssm_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(DATA_W)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(ctrl_i.start),
    .num_i  (prod_q),
    .den_i  ({1'b0, trange_i}),
    .neg_i  (1'b0),
    .busy_o (busy_o),
    .quot_o (quot)
  );

  assign col_o = quot + DATA_W'(LEFT_MARGIN);

endmodule

FILE: src/scope_trace_segment_mapper.sv
// Maps one timestamped sample of up to five channel values onto a pixel plot and
// returns one line segment per active channel, in channel order, each running from
// the channel's previous point to its new point; a sample whose column passes the
// plot width flags its segments wrapped and restarts the trace at the left margin.
// A sample is captured, multiplied and divided, and then its segments are handed out
// one per accepted handshake: every channel has its own scaling lane, and the column
// and the shared row offset have their own units, all using a one-bit-per-cycle
// 32-step divider that runs in parallel with the others. A new sample is taken
// once the last segment of the previous one has been handed over. Registers sit on an
// APB port at byte offsets 0x0 time_range, 0x4 y_min, 0x8 y_max, 0xC channel_count and
// must be written only while the block is idle.
module scope_trace_segment_mapper import ssm_pkg::*; #(
  parameter int PLOT_WIDTH    = 320,
  parameter int PLOT_HEIGHT   = 240,
  parameter int LEFT_MARGIN   = 30,
  parameter int BOTTOM_MARGIN = 20,
  parameter int MAX_CHANNELS  = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DATA_W-1:0] sample_time_i,
  input  logic [DATA_W-1:0] value_0_i,
  input  logic [DATA_W-1:0] value_1_i,
  input  logic [DATA_W-1:0] value_2_i,
  input  logic [DATA_W-1:0] value_3_i,
  input  logic [DATA_W-1:0] value_4_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] x_start_o,
  output logic [DATA_W-1:0] y_start_o,
  output logic [DATA_W-1:0] x_end_o,
  output logic [DATA_W-1:0] y_end_o,
  output logic [CH_W-1:0]   channel_o,
  output logic              wrapped_o,
  output logic              last_o
);

  localparam int H_VAL = PLOT_HEIGHT - BOTTOM_MARGIN;
  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  typedef enum logic [1:0] {
    REG_TIME_RANGE,
    REG_Y_MIN,
    REG_Y_MAX,
    REG_CHANNEL_COUNT
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_START,
    S_DIV,
    S_EMIT
  } state_e;

  state_e            state_q;
  logic [DATA_W-1:0] trange_q, ymin_q, ymax_q;
  logic [CH_W-1:0]   ccount_q, n_now, n_q;
  logic [IDX_W-1:0]  idx_q;
  logic [DATA_W-1:0] prev_col_q, wrap_cnt_q, xs_q, col_q;
  logic              wrap_q;
  logic [DATA_W-1:0] prev_rows_q [MAX_CHANNELS];
  logic [DATA_W-1:0] new_rows_q [MAX_CHANNELS];
  logic [DATA_W-1:0] lane_row [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] lane_busy;
  logic [DATA_W-1:0] val [5];

  logic              cfg_wr, in_acc, out_acc, all_idle, col_busy, off_busy, col_wrap;
  logic [DATA_W-1:0] col, off;
  logic [DEN_W-1:0]  dfull;
  logic signed [NUM_W-1:0] oprod;
  logic [NUM_W-1:0]  omag_q;
  logic              oneg_q;
  ssm_ctrl_t         ctrl;
  ssm_lane_cfg_t     lcfg;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trange_q <= 16'd1000;
      ymin_q   <= 16'hff9c;
      ymax_q   <= 16'd100;
      ccount_q <= 3'd1;
    end else if (cfg_wr) begin
      case (reg_e'(paddr[3:2]))
        REG_TIME_RANGE:    trange_q <= pwdata[DATA_W-1:0];
        REG_Y_MIN:         ymin_q   <= pwdata[DATA_W-1:0];
        REG_Y_MAX:         ymax_q   <= pwdata[DATA_W-1:0];
        REG_CHANNEL_COUNT: ccount_q <= pwdata[CH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[3:2]))
      REG_TIME_RANGE:    prdata = 32'(trange_q);
      REG_Y_MIN:         prdata = {{16{ymin_q[15]}}, ymin_q};
      REG_Y_MAX:         prdata = {{16{ymax_q[15]}}, ymax_q};
      REG_CHANNEL_COUNT: prdata = 32'(ccount_q);
      default:           prdata = '0;
    endcase
  end

  // handshake and lane control
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_valid_o = (state_q == S_EMIT);
  assign out_acc     = out_valid_o & out_ready_i;
  assign ctrl.cap    = in_acc;
  assign ctrl.mul    = (state_q == S_MUL);
  assign ctrl.start  = (state_q == S_START);
  assign all_idle    = !(|lane_busy) && !col_busy && !off_busy;

  assign n_now = (ccount_q > CH_W'(MAX_CHANNELS)) ? CH_W'(MAX_CHANNELS) : ccount_q;

  assign dfull = {ymax_q[15], ymax_q} - {ymin_q[15], ymin_q};
  assign oprod = NUM_W'($signed(ymin_q)) * NUM_W'(H_VAL);

  always_ff @(posedge clk_i) begin
    if (ctrl.mul) begin
      oneg_q <= oprod[NUM_W-1];
      omag_q <= oprod[NUM_W-1] ? NUM_W'(-oprod) : NUM_W'(oprod);
    end
  end

  ssm_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(DATA_W)) u_off_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(ctrl.start),
    .num_i  (omag_q),
    .den_i  (dfull[DEN_W-1] ? DEN_W'(~dfull + DEN_W'(1)) : dfull),
    .neg_i  (oneg_q ^ dfull[DEN_W-1]),
    .busy_o (off_busy),
    .quot_o (off)
  );

  assign lcfg.y_min = ymin_q;
  assign lcfg.y_max = ymax_q;
  assign lcfg.dmag  = dfull[DEN_W-1] ? DEN_W'(~dfull + DEN_W'(1)) : dfull;
  assign lcfg.dneg  = dfull[DEN_W-1];
  assign lcfg.off   = off;

  assign val[0] = value_0_i;
  assign val[1] = value_1_i;
  assign val[2] = value_2_i;
  assign val[3] = value_3_i;
  assign val[4] = value_4_i;

  for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
    ssm_lane #(.H_VAL(H_VAL)) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .cfg_i  (lcfg),
      .value_i(val[g]),
      .busy_o (lane_busy[g]),
      .row_o  (lane_row[g])
    );
  end

  ssm_col #(.PLOT_WIDTH(PLOT_WIDTH), .LEFT_MARGIN(LEFT_MARGIN)) u_col (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .time_i    (sample_time_i),
    .wrap_cnt_i(wrap_cnt_q),
    .trange_i  (trange_q),
    .busy_o    (col_busy),
    .col_o     (col)
  );

  assign col_wrap = (col > DATA_W'(PLOT_WIDTH));

  // sequencer and segment merge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      n_q        <= '0;
      idx_q      <= '0;
      prev_col_q <= DATA_W'(LEFT_MARGIN);
      wrap_cnt_q <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        prev_rows_q[i] <= '0;
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            n_q     <= n_now;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_START;
        end
        S_START: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (all_idle) begin
            idx_q <= '0;
            if (col_wrap) begin
              wrap_cnt_q <= wrap_cnt_q + DATA_W'(1);
              prev_col_q <= DATA_W'(LEFT_MARGIN);
            end else begin
              prev_col_q <= col;
            end
            state_q <= (n_q == '0) ? S_IDLE : S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_acc) begin
            if (last_o) begin
              for (int i = 0; i < MAX_CHANNELS; i++) begin
                if (CH_W'(i) < n_q) begin
                  prev_rows_q[i] <= new_rows_q[i];
                end
              end
              state_q <= S_IDLE;
            end else begin
              idx_q <= idx_q + IDX_W'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DIV && all_idle) begin
      xs_q   <= prev_col_q;
      col_q  <= col;
      wrap_q <= col_wrap;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        new_rows_q[i] <= lane_row[i];
      end
    end
  end

  assign x_start_o = xs_q;
  assign y_start_o = prev_rows_q[idx_q];
  assign x_end_o   = col_q;
  assign y_end_o   = new_rows_q[idx_q];
  assign channel_o = CH_W'(idx_q);
  assign wrapped_o = wrap_q;
  assign last_o    = (CH_W'(idx_q) == n_q - CH_W'(1));

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("request offered while segments pending");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CH_W'(idx_q) < n_q))
    else $error("segment index beyond channel count");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_o) |=> in_ready_o)
    else $error("block not ready after final segment");

  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.start |=> !all_idle)
    else $error("dividers did not start");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import ssm_pkg::*;

  localparam int PLOT_W    = 320;
  localparam int PLOT_H    = 240;
  localparam int LEFT_M    = 30;
  localparam int BOTTOM_M  = 20;
  localparam int MAX_CH    = 5;
  localparam int LIMIT     = 400000;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE    = 60;

  typedef enum logic [3:0] {
    REG_TIME_RANGE = 4'h0,
    REG_Y_MIN      = 4'h4,
    REG_Y_MAX      = 4'h8,
    REG_CHAN_COUNT = 4'hC
  } reg_addr_e;

  typedef struct packed {
    logic [DATA_W-1:0]        stamp;
    logic [4:0][DATA_W-1:0]   vals;
  } sample_t;

  typedef struct packed {
    logic [DATA_W-1:0] xs;
    logic [DATA_W-1:0] ys;
    logic [DATA_W-1:0] xe;
    logic [DATA_W-1:0] ye;
    logic [CH_W-1:0]   ch;
    logic              wr;
    logic              lst;
  } segment_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [DATA_W-1:0] sample_time_i = '0;
  logic [DATA_W-1:0] value_0_i = '0;
  logic [DATA_W-1:0] value_1_i = '0;
  logic [DATA_W-1:0] value_2_i = '0;
  logic [DATA_W-1:0] value_3_i = '0;
  logic [DATA_W-1:0] value_4_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [DATA_W-1:0] x_start_o;
  logic [DATA_W-1:0] y_start_o;
  logic [DATA_W-1:0] x_end_o;
  logic [DATA_W-1:0] y_end_o;
  logic [CH_W-1:0]   channel_o;
  logic              wrapped_o;
  logic              last_o;

  scope_trace_segment_mapper #(
    .PLOT_WIDTH   (PLOT_W),
    .PLOT_HEIGHT  (PLOT_H),
    .LEFT_MARGIN  (LEFT_M),
    .BOTTOM_MARGIN(BOTTOM_M),
    .MAX_CHANNELS (MAX_CH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_time_i(sample_time_i),
    .value_0_i    (value_0_i),
    .value_1_i    (value_1_i),
    .value_2_i    (value_2_i),
    .value_3_i    (value_3_i),
    .value_4_i    (value_4_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .x_start_o    (x_start_o),
    .y_start_o    (y_start_o),
    .x_end_o      (x_end_o),
    .y_end_o      (y_end_o),
    .channel_o    (channel_o),
    .wrapped_o    (wrapped_o),
    .last_o       (last_o)
  );

  // mirror of the block's registers and trace state
  logic [15:0]        cfg_range = 16'd1000;
  logic signed [15:0] cfg_y_min = -16'sd100;
  logic signed [15:0] cfg_y_max = 16'sd100;
  logic [2:0]         cfg_chans = 3'd1;
  logic [15:0]        last_column = 16'(LEFT_M);
  logic [15:0]        last_rows [5] = '{default: 16'd0};
  logic [15:0]        wrap_count = '0;

  sample_t  sample_q [$];
  segment_t segment_q [$];

  int       samples_taken = 0;
  int       segments_seen = 0;
  int       wraps_seen = 0;
  int       mismatches = 0;
  int       cfg_sets = 0;
  int       cycles = 0;
  int       send_gap = 0;
  int       rx_gap = 0;
  logic     burst_mode = 1'b0;
  logic     hold_req = 1'b0;
  logic     long_hold_done = 1'b0;
  logic [15:0] stamp_now = '0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] column_for(input logic [15:0] stamp);
    logic [15:0] rel;
    longint      q;
    rel = stamp - wrap_count * cfg_range;
    q = 0;
    if (cfg_range != 0) q = (longint'(rel) * (PLOT_W - LEFT_M)) / longint'(cfg_range);
    return 16'(q + LEFT_M);
  endfunction

  function automatic logic [15:0] row_for(input logic signed [15:0] v);
    longint             h;
    longint             d;
    longint             off;
    longint             q;
    longint             vv;
    longint             tmp;
    logic signed [15:0] off16;
    h = PLOT_H - BOTTOM_M;
    d = longint'(cfg_y_max) - longint'(cfg_y_min);
    vv = v;
    if (vv > longint'(cfg_y_max)) vv = cfg_y_max;
    else if (vv < longint'(cfg_y_min)) vv = cfg_y_min;
    off = 0;
    q = 0;
    if (d != 0) begin
      tmp = (longint'(cfg_y_min) * h) / d;
      off16 = tmp[15:0];
      off = off16;
      q = (vv * h) / d;
    end
    tmp = h - q + off;
    return tmp[15:0];
  endfunction

  task automatic map_sample(input sample_t s);
    logic [15:0] col;
    logic        wrap;
    int          n;
    logic [15:0] rows [5];
    segment_t    seg;
    col = column_for(s.stamp);
    wrap = col > 16'(PLOT_W);
    n = (cfg_chans > MAX_CH) ? MAX_CH : cfg_chans;
    for (int i = 0; i < n; i++) begin
      rows[i] = row_for(s.vals[i]);
      seg.xs  = last_column;
      seg.ys  = last_rows[i];
      seg.xe  = col;
      seg.ye  = rows[i];
      seg.ch  = CH_W'(i);
      seg.wr  = wrap;
      seg.lst = (i == n - 1);
      segment_q.push_back(seg);
    end
    if (wrap) begin
      wrap_count = wrap_count + 16'd1;
      last_column = 16'(LEFT_M);
    end else begin
      last_column = col;
    end
    for (int i = 0; i < n; i++) last_rows[i] = rows[i];
  endtask

  // request driver
  always @(posedge clk_i) begin
    sample_t nxt;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        map_sample({sample_time_i, value_4_i, value_3_i, value_2_i, value_1_i, value_0_i});
        samples_taken <= samples_taken + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (sample_q.size() > 0) begin
          nxt = sample_q.pop_front();
          sample_time_i <= nxt.stamp;
          value_0_i     <= nxt.vals[0];
          value_1_i     <= nxt.vals[1];
          value_2_i     <= nxt.vals[2];
          value_3_i     <= nxt.vals[3];
          value_4_i     <= nxt.vals[4];
          in_valid_i    <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_req && !long_hold_done) begin
        long_hold_done <= 1'b1;
        rx_gap = LONG_HOLD;
      end
      if (rx_gap > 0) begin
        rx_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) rx_gap = pick_gap();
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    segment_t got;
    segment_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {x_start_o, y_start_o, x_end_o, y_end_o, channel_o, wrapped_o, last_o};
      segments_seen <= segments_seen + 1;
      if (wrapped_o && last_o) wraps_seen <= wraps_seen + 1;
      if (segment_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected segment: xs=%0d ys=%0d xe=%0d ye=%0d ch=%0d wr=%0b last=%0b",
                   got.xs, got.ys, got.xe, got.ye, got.ch, got.wr, got.lst);
      end else begin
        want = segment_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("segment mismatch at %0t", $realtime);
            $display("  exp xs=%0d ys=%0d xe=%0d ye=%0d ch=%0d wr=%0b last=%0b",
                     want.xs, want.ys, want.xe, want.ye, want.ch, want.wr, want.lst);
            $display("  got xs=%0d ys=%0d xe=%0d ye=%0d ch=%0d wr=%0b last=%0b",
                     got.xs, got.ys, got.xe, got.ye, got.ch, got.wr, got.lst);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d segments still expected", cycles, segment_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic apb_write(input reg_addr_e addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr)
      REG_TIME_RANGE: cfg_range = data[15:0];
      REG_Y_MIN:      cfg_y_min = data[15:0];
      REG_Y_MAX:      cfg_y_max = data[15:0];
      REG_CHAN_COUNT: cfg_chans = data[2:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] tr, input logic [15:0] lo,
                            input logic [15:0] hi, input logic [2:0] chans);
    apb_write(REG_TIME_RANGE, {16'd0, tr});
    apb_write(REG_Y_MIN, {16'd0, lo});
    apb_write(REG_Y_MAX, {16'd0, hi});
    apb_write(REG_CHAN_COUNT, {29'd0, chans});
    cfg_sets++;
    @(negedge clk_i);
  endtask

  task automatic push_sample(input logic [15:0] t, input logic [15:0] v0, input logic [15:0] v1,
                             input logic [15:0] v2, input logic [15:0] v3,
                             input logic [15:0] v4);
    sample_q.push_back({t, v4, v3, v2, v1, v0});
  endtask

  task automatic drain_all();
    do @(negedge clk_i);
    while (sample_q.size() != 0 || in_valid_i || segment_q.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_value();
    int r;
    int lo;
    int hi;
    r = $urandom_range(0, 9);
    lo = (cfg_y_min < cfg_y_max) ? cfg_y_min : cfg_y_max;
    hi = (cfg_y_min < cfg_y_max) ? cfg_y_max : cfg_y_min;
    lo = (lo - 10 < -32768) ? -32768 : lo - 10;
    hi = (hi + 10 > 32767) ? 32767 : hi + 10;
    if (r < 6) return 16'(lo + int'($urandom_range(0, hi - lo)));
    if (r < 8) return 16'($urandom);
    if (r == 8) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    return $urandom_range(0, 1) ? cfg_y_min : cfg_y_max;
  endfunction

  function automatic logic [15:0] rand_stamp();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    stamp_now = stamp_now + 16'($urandom_range(1, cfg_range / 8 + 1));
    return stamp_now;
  endfunction

  task automatic push_random(input int count);
    for (int i = 0; i < count; i++)
      push_sample(rand_stamp(), rand_value(), rand_value(), rand_value(), rand_value(),
                  rand_value());
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings, single channel, wrap past the right edge
    push_sample(16'd0, 16'd0, '0, '0, '0, '0);
    push_sample(16'd500, 16'h7FFF, '0, '0, '0, '0);
    push_sample(16'd999, 16'h8000, '0, '0, '0, '0);
    push_sample(16'd1200, 16'd100, '0, '0, '0, '0);
    push_sample(16'd1500, -16'sd100, '0, '0, '0, '0);
    drain_all();

    // widest range, all five channels at the field extremes
    set_config(16'hFFFF, 16'h8000, 16'h7FFF, 3'd5);
    push_sample(16'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    push_sample(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_sample(16'h5555, 16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h0001);
    drain_all();

    // zero time range, equal y limits, channel count above the maximum
    set_config(16'd0, 16'd5, 16'd5, 3'd7);
    push_sample(16'd1234, 16'd5, 16'd4, 16'd6, 16'h8000, 16'h7FFF);
    push_sample(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    drain_all();

    // inverted y limits with the smallest nonzero time range
    set_config(16'd1, 16'd50, -16'sd50, 3'd3);
    push_sample(16'd3, 16'd100, -16'sd100, 16'd0, '0, '0);
    push_sample(16'd4, -16'sd100, 16'd100, 16'd50, '0, '0);
    push_sample(16'd9, 16'd0, 16'd60, -16'sd60, '0, '0);
    drain_all();

    // no active channel: column and wrap state still move
    set_config(16'd200, -16'sd10, 16'd10, 3'd0);
    push_sample(16'd100, 16'd1, '0, '0, '0, '0);
    push_sample(16'd300, 16'd2, '0, '0, '0, '0);
    push_sample(16'd450, 16'd3, '0, '0, '0, '0);
    drain_all();

    set_config(16'd2000, 16'd0, 16'd1, 3'd4);
    push_sample(16'd1000, 16'd1, 16'd0, 16'hFFFF, 16'd2, '0);
    push_sample(16'd3000, 16'd0, 16'd1, 16'd1, 16'd0, '0);
    drain_all();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config(16'hFFFF, 16'h8000, 16'h7FFF, 3'd7);
        1: set_config(16'd1, 16'h7FFF, 16'h8000, 3'd5);
        default: begin
          if ($urandom_range(0, 9) < 7) begin
            logic [15:0] lo;
            lo = 16'($urandom_range(0, 4000) - 2000);
            set_config(16'($urandom_range(50, 4000)), lo,
                       lo + 16'($urandom_range(1, 3000)), 3'($urandom_range(1, 5)));
          end else begin
            set_config(16'($urandom), 16'($urandom), 16'($urandom), 3'($urandom_range(1, 7)));
          end
        end
      endcase
      burst_mode = (p == 3);
      push_random(18);
      if (p == 2) hold_req = 1'b1;
      if (p == 4) drain_all();
      push_random(18);
      drain_all();
    end

    $display("checked %0d segments from %0d samples (%0d wrapped) over %0d register settings",
             segments_seen, samples_taken, wraps_seen, cfg_sets);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
